// File: sv/pal_pkg.sv
// ----------------------------------------------------------------------------
// pal_pkg
// Shared constants and types for the positional array list.
// ----------------------------------------------------------------------------
package pal_pkg;

  localparam int unsigned CAPACITY_DEF = 128;
  localparam int unsigned SCAN_GROUP   = 8;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned POS_W        = 8;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_DELETE = 2'd1;
  localparam logic [1:0] KIND_LOCATE = 2'd2;
  localparam logic [1:0] KIND_CLEAR  = 2'd3;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_BAD_POS = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;

  typedef struct packed {
    logic ins;
    logic del;
    logic search_ld;
    logic scan_step;
  } pal_ctrl_t;

endpackage

// File: sv/pal_cell.sv
// ----------------------------------------------------------------------------
// pal_cell
// One list entry: shifts up or down with its neighbours, compares and
// passes match flags towards the head of the chain.
// ----------------------------------------------------------------------------
module pal_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned PW  = 9,
  parameter int unsigned CW  = 8
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  pal_pkg::pal_ctrl_t                     ctrl_i,
  input  logic [PW-1:0]                          pos_m1_i,
  input  logic [CW-1:0]                          count_i,
  input  logic signed [pal_pkg::VALUE_W-1:0]     key_i,
  input  logic signed [pal_pkg::VALUE_W-1:0]     left_i,
  input  logic signed [pal_pkg::VALUE_W-1:0]     right_i,
  input  logic                                   match_nb_i,
  output logic signed [pal_pkg::VALUE_W-1:0]     data_o,
  output logic                                   match_o
);

  logic signed [pal_pkg::VALUE_W-1:0] data_q, data_d;
  logic                               match_q, match_d;
  logic                               at_pos, past_pos, live;

  assign at_pos   = (pos_m1_i == PW'(IDX));
  assign past_pos = (pos_m1_i <  PW'(IDX));
  assign live     = (CW'(IDX) < count_i);

  always_comb begin
    data_d = data_q;
    if (ctrl_i.ins) begin
      if (at_pos) begin
        data_d = key_i;
      end else if (past_pos) begin
        data_d = left_i;
      end
    end else if (ctrl_i.del) begin
      if (at_pos || past_pos) begin
        data_d = right_i;
      end
    end
  end

  always_comb begin
    match_d = match_q;
    if (ctrl_i.search_ld) begin
      match_d = live && (data_q == key_i);
    end else if (ctrl_i.scan_step) begin
      match_d = match_nb_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  assign data_o  = data_q;
  assign match_o = match_q;

endmodule

// File: sv/pal_scan.sv
// ----------------------------------------------------------------------------
// pal_scan
// Walks the match flags arriving at the head of the chain, one group per
// cycle, and reports the first matching position.
// ----------------------------------------------------------------------------
module pal_scan #(
  parameter int unsigned CAPACITY = pal_pkg::CAPACITY_DEF,
  parameter int unsigned CW       = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pal_pkg::pal_ctrl_t                ctrl_i,
  input  logic [pal_pkg::SCAN_GROUP-1:0]    grp_i,
  input  logic [CW-1:0]                     count_i,
  output logic                              done_o,
  output logic [CW-1:0]                     found_o
);

  localparam int unsigned G  = pal_pkg::SCAN_GROUP;
  localparam int unsigned SW = $clog2(CAPACITY + G + 1);
  localparam int unsigned EW = $clog2(G);

  logic [SW-1:0] base_q, base_d;
  logic [EW-1:0] enc;
  logic          hit;
  logic          past_end;
  logic [SW-1:0] pos_sum;

  always_comb begin
    enc = '0;
    for (int i = G - 1; i >= 0; i--) begin
      if (grp_i[i]) begin
        enc = EW'(i);
      end
    end
  end

  assign hit      = |grp_i;
  assign past_end = ((base_q + SW'(G)) >= SW'(count_i));
  assign done_o   = hit || past_end;
  assign pos_sum  = base_q + SW'(enc) + SW'(1);
  assign found_o  = hit ? pos_sum[CW-1:0] : '0;

  always_comb begin
    base_d = base_q;
    if (ctrl_i.search_ld) begin
      base_d = '0;
    end else if (ctrl_i.scan_step) begin
      base_d = base_q + SW'(G);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else begin
      base_q <= base_d;
    end
  end

endmodule

// File: sv/positional_array_list.sv
// ----------------------------------------------------------------------------
// positional_array_list
// Ordered list of signed 32-bit values held in a chain of entry cells.
// ----------------------------------------------------------------------------
// Insert, delete and clear complete in the cycle they are accepted and give a
// result beat the next cycle, so they sustain one beat per cycle while the
// result side keeps up. Locate compares every cell at once, then shifts the
// match flags down the chain eight cells per cycle into the scanner, which stops
// at the first match or at the end of the list; no new beat is taken until the
// locate result is written. Entry contents have no reset.
// ----------------------------------------------------------------------------
module positional_array_list #(
  parameter int unsigned CAPACITY = pal_pkg::CAPACITY_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // position[7:0], value[39:8]
  input  logic [1:0]  s_axis_tuser,   // kind[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // status[1:0], found_position[9:2],
                                      // list_length[17:10], is_empty[18],
                                      // is_full[19], zero[23:20]
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = ((CW > pal_pkg::POS_W) ? CW : pal_pkg::POS_W) + 1;
  localparam int unsigned G  = pal_pkg::SCAN_GROUP;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                               state_q, state_d;
  logic [CW-1:0]                      count_q, count_d;
  logic                               m_valid_q, m_valid_d;
  logic [23:0]                        m_data_q, m_data_d;

  logic [1:0]                         kind;
  logic [pal_pkg::POS_W-1:0]          pos;
  logic signed [pal_pkg::VALUE_W-1:0] key;
  logic                               acc, out_free;
  logic [PW-1:0]                      pos_x, cnt_x, pos_m1;
  logic                               ins_bad, del_bad, is_full_now;
  pal_pkg::pal_ctrl_t                 ctrl;
  logic [1:0]                         status;
  logic                               wr_imm, wr_scan;
  logic                               scan_done;
  logic [CW-1:0]                      scan_found;
  logic [CW+7:0]                      len_ext, found_ext;

  logic signed [pal_pkg::VALUE_W-1:0] data_w [CAPACITY];
  logic [CAPACITY-1:0]                match_w;
  logic [CAPACITY+G-1:0]              match_pad;

  assign kind = s_axis_tuser;
  assign pos  = s_axis_tdata[7:0];
  assign key  = s_axis_tdata[39:8];

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  assign acc           = s_axis_tvalid && s_axis_tready;

  assign pos_x       = PW'(pos);
  assign cnt_x       = PW'(count_q);
  assign pos_m1      = pos_x - PW'(1);
  assign ins_bad     = (pos == '0) || (pos_x > (cnt_x + PW'(1)));
  assign del_bad     = (pos == '0) || (pos_x > cnt_x);
  assign is_full_now = (count_q == CW'(CAPACITY));

  assign ctrl.ins       = acc && (kind == pal_pkg::KIND_INSERT) && !ins_bad && !is_full_now;
  assign ctrl.del       = acc && (kind == pal_pkg::KIND_DELETE) && !del_bad;
  assign ctrl.search_ld = acc && (kind == pal_pkg::KIND_LOCATE);
  assign ctrl.scan_step = (state_q == S_SCAN) && !scan_done;

  always_comb begin
    status = pal_pkg::STAT_OK;
    case (kind)
      pal_pkg::KIND_INSERT: begin
        if (ins_bad) begin
          status = pal_pkg::STAT_BAD_POS;
        end else if (is_full_now) begin
          status = pal_pkg::STAT_FULL;
        end
      end
      pal_pkg::KIND_DELETE: begin
        if (del_bad) begin
          status = pal_pkg::STAT_BAD_POS;
        end
      end
      default: begin
        status = pal_pkg::STAT_OK;
      end
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.ins) begin
      count_d = count_q + CW'(1);
    end else if (ctrl.del) begin
      count_d = count_q - CW'(1);
    end else if (acc && (kind == pal_pkg::KIND_CLEAR)) begin
      count_d = '0;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (ctrl.search_ld) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_done && out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign wr_imm    = acc && (kind != pal_pkg::KIND_LOCATE);
  assign wr_scan   = (state_q == S_SCAN) && scan_done && out_free;
  assign len_ext   = {8'b0, count_d};
  assign found_ext = {8'b0, scan_found};

  always_comb begin
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    if (wr_imm || wr_scan) begin
      m_valid_d       = 1'b1;
      m_data_d        = '0;
      m_data_d[1:0]   = wr_scan ? pal_pkg::STAT_OK : status;
      m_data_d[9:2]   = wr_scan ? found_ext[7:0] : 8'd0;
      m_data_d[17:10] = len_ext[7:0];
      m_data_d[18]    = (count_d == '0);
      m_data_d[19]    = (count_d == CW'(CAPACITY));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [pal_pkg::VALUE_W-1:0] left_w, right_w;
    logic                               nb_w;

    if (i == 0) begin : g_head
      assign left_w = key;
    end else begin : g_mid
      assign left_w = data_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_w = data_w[i];
    end else begin : g_next
      assign right_w = data_w[i+1];
    end

    if (i + G < CAPACITY) begin : g_nb
      assign nb_w = match_w[i+G];
    end else begin : g_nb_end
      assign nb_w = 1'b0;
    end

    pal_cell #(
      .IDX (i),
      .PW  (PW),
      .CW  (CW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .pos_m1_i   (pos_m1),
      .count_i    (count_q),
      .key_i      (key),
      .left_i     (left_w),
      .right_i    (right_w),
      .match_nb_i (nb_w),
      .data_o     (data_w[i]),
      .match_o    (match_w[i])
    );
  end

  assign match_pad = {{G{1'b0}}, match_w};

  pal_scan #(
    .CAPACITY (CAPACITY),
    .CW       (CW)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .grp_i   (match_pad[G-1:0]),
    .count_i (count_q),
    .done_o  (scan_done),
    .found_o (scan_found)
  );

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("list length beyond capacity");

  a_scan_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !s_axis_tready)
    else $error("beat accepted during locate scan");

  a_imm_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && (kind != pal_pkg::KIND_LOCATE)) |=> m_axis_tvalid)
    else $error("no result after insert, delete or clear");

  a_locate_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.search_ld |=> (state_q == S_SCAN))
    else $error("locate did not start a scan");

  a_count_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |=> $stable(count_q))
    else $error("length changed during locate");
`endif

endmodule

// File: tb/sv/tb_positional_array_list.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_positional_array_list
// Self-checking bench for the positional array list.
// ----------------------------------------------------------------------------
// A short directed list hits the edges: empty-list rejects, front, middle and
// end inserts, duplicate values, bad positions, clear. Randomised grow, shrink
// and mixed phases follow: the list is filled to capacity and drained again.
// Every accepted request goes through a shadow list, and each result beat is
// compared against the oldest prediction. Both sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb_positional_array_list;

  localparam int CAP      = pal_pkg::CAPACITY_DEF;
  localparam int N_RANDOM = 700;
  localparam int N_TAIL   = 80;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  pos;
    logic [31:0] val;
    int          gap;
    bit          drain;
    bit          tail;
  } list_op_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] found;
    logic [7:0] len;
    logic       empty;
    logic       full;
  } list_res_t;

  typedef enum {PH_GROW, PH_SHRINK, PH_MIXED} phase_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // position[7:0], value[39:8]
  logic [1:0]  s_axis_tuser = '0;   // kind[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // status[1:0], found_position[9:2],
                                    // list_length[17:10], is_empty[18],
                                    // is_full[19]

  list_op_t    op_q[$];
  list_res_t   exp_res_q[$];

  // shadow list
  logic [31:0] list_mem [CAP];
  int          list_len = 0;

  // generator state
  int          gen_len = 0;
  bit          gen_gaps = 1'b1;
  logic [31:0] val_pool [8];

  int          beats_sent = 0;
  int          beats_in = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  int          sink_cyc = 0;
  bit          quiet = 1'b0;
  int          err_cnt = 0;
  int          n_res = 0;

  int          n_kind [4] = '{0, 0, 0, 0};
  int          n_full_rej = 0;
  int          n_bad = 0;
  int          n_hit = 0;
  int          peak_len = 0;

  positional_array_list #(
    .CAPACITY(CAP)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  function automatic list_res_t list_model_step(logic [1:0] k, logic [7:0] p,
                                                logic [31:0] v);
    list_res_t r;
    int j;
    int pi;
    r = '0;
    pi = p;
    n_kind[k]++;
    case (k)
      pal_pkg::KIND_INSERT: begin
        if (pi < 1 || pi > list_len + 1) begin
          r.status = pal_pkg::STAT_BAD_POS;
        end else if (list_len >= CAP) begin
          r.status = pal_pkg::STAT_FULL;
        end else begin
          for (j = list_len; j >= pi; j--) list_mem[j] = list_mem[j-1];
          list_mem[pi-1] = v;
          list_len++;
        end
      end
      pal_pkg::KIND_DELETE: begin
        if (pi < 1 || pi > list_len) begin
          r.status = pal_pkg::STAT_BAD_POS;
        end else begin
          for (j = pi; j < list_len; j++) list_mem[j-1] = list_mem[j];
          list_len--;
        end
      end
      pal_pkg::KIND_LOCATE: begin
        for (j = 0; j < list_len; j++) begin
          if (list_mem[j] == v) begin
            r.found = 8'(j + 1);
            break;
          end
        end
      end
      pal_pkg::KIND_CLEAR: begin
        list_len = 0;
      end
    endcase
    r.len   = 8'(list_len);
    r.empty = (list_len == 0);
    r.full  = (list_len == CAP);
    if (r.status == pal_pkg::STAT_FULL) n_full_rej++;
    if (r.status == pal_pkg::STAT_BAD_POS) n_bad++;
    if (r.found != 0) n_hit++;
    if (list_len > peak_len) peak_len = list_len;
    return r;
  endfunction

  task automatic push_op(input logic [1:0] k, input int p, input logic [31:0] v,
                         input bit drain);
    list_op_t o;
    o.kind  = k;
    o.pos   = p[7:0];
    o.val   = v;
    o.drain = drain;
    o.tail  = 1'b0;
    o.gap   = (gen_gaps && $urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : 0;
    case (k)
      pal_pkg::KIND_INSERT: if (p >= 1 && p <= gen_len + 1 && gen_len < CAP) gen_len++;
      pal_pkg::KIND_DELETE: if (p >= 1 && p <= gen_len) gen_len--;
      pal_pkg::KIND_LOCATE: ;
      pal_pkg::KIND_CLEAR:  gen_len = 0;
    endcase
    op_q.push_back(o);
  endtask

  function automatic logic [31:0] pick_value(int pool_pct);
    if ($urandom_range(0, 99) < pool_pct) return val_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  function automatic int pick_pos(logic [1:0] k);
    int top;
    int r;
    top = (k == pal_pkg::KIND_INSERT) ? gen_len + 1 : gen_len;
    r = $urandom_range(0, 9);
    if (top == 0 || r == 0) begin
      return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(top + 1, 255);
    end
    if (r == 1) return 1;
    if (r == 2) return top;
    return $urandom_range(1, top);
  endfunction

  task automatic gen_phase(input phase_e ph, input int n);
    int i;
    int r;
    int w_ins;
    int w_del;
    int w_loc;
    logic [1:0] k;
    case (ph)
      PH_GROW:   begin w_ins = 80; w_del = 5;  w_loc = 15; end
      PH_SHRINK: begin w_ins = 10; w_del = 70; w_loc = 18; end
      PH_MIXED:  begin w_ins = 40; w_del = 35; w_loc = 24; end
    endcase
    for (i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < w_ins) k = pal_pkg::KIND_INSERT;
      else if (r < w_ins + w_del) k = pal_pkg::KIND_DELETE;
      else if (r < w_ins + w_del + w_loc) k = pal_pkg::KIND_LOCATE;
      else k = pal_pkg::KIND_CLEAR;
      case (k)
        pal_pkg::KIND_INSERT: push_op(k, pick_pos(k), pick_value(50), i == 0);
        pal_pkg::KIND_DELETE: push_op(k, pick_pos(k), pick_value(50), i == 0);
        pal_pkg::KIND_LOCATE: push_op(k, $urandom_range(0, 255), pick_value(70), i == 0);
        pal_pkg::KIND_CLEAR:  push_op(k, $urandom_range(0, 255), $urandom, i == 0);
      endcase
    end
  endtask

  // request driver
  always @(negedge clk_i) begin : drv
    logic        nv;
    logic [39:0] nd;
    logic [1:0]  nu;
    list_op_t    o;
    nv = s_axis_tvalid;
    nd = s_axis_tdata;
    nu = s_axis_tuser;
    if (rst_ni && !(s_axis_tvalid && beats_in < beats_sent)) begin
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (op_q.size() > 0) begin
        if (op_q[0].gap > 0) begin
          gap_left = op_q[0].gap - 1;
          op_q[0].gap = 0;
        end else if (!(op_q[0].drain && exp_res_q.size() != 0)) begin
          o = op_q.pop_front();
          nv = 1'b1;
          nd = {o.val, o.pos};
          nu = o.kind;
          beats_sent++;
          if (o.tail) quiet = 1'b1;
        end
      end
    end
    s_axis_tvalid <= nv;
    s_axis_tdata  <= nd;
    s_axis_tuser  <= nu;
  end

  // result sink with stall bursts
  always @(negedge clk_i) begin : sink
    sink_cyc++;
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!quiet && (sink_cyc % 384) < 256 && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 3);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // acceptance, prediction and checking
  always @(posedge clk_i) begin : mon
    list_res_t got;
    list_res_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[1:0], m_axis_tdata[9:2], m_axis_tdata[17:10],
               m_axis_tdata[18], m_axis_tdata[19]};
        n_res++;
        if (exp_res_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: unexpected result beat st=%0d fp=%0d len=%0d e=%0b f=%0b",
                     $realtime, got.status, got.found, got.len, got.empty, got.full);
        end else begin
          want = exp_res_q.pop_front();
          if (got.status !== want.status || got.found !== want.found ||
              got.len !== want.len || got.empty !== want.empty ||
              got.full !== want.full) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display({"%0t: result %0d: exp st=%0d fp=%0d len=%0d e=%0b f=%0b, ",
                        "got st=%0d fp=%0d len=%0d e=%0b f=%0b"},
                       $realtime, n_res, want.status, want.found, want.len,
                       want.empty, want.full, got.status, got.found, got.len,
                       got.empty, got.full);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        beats_in++;
        exp_res_q.push_back(list_model_step(s_axis_tuser, s_axis_tdata[7:0],
                                            s_axis_tdata[39:8]));
      end
    end
  end

  initial begin : main
    int i;
    int n;
    int r;
    val_pool[0] = 32'h0000_0000;
    val_pool[1] = 32'hFFFF_FFFF;
    val_pool[2] = 32'h8000_0000;
    val_pool[3] = 32'h7FFF_FFFF;
    for (i = 4; i < 8; i++) val_pool[i] = $urandom;

    // empty-list rejects, then build a five-entry list
    push_op(pal_pkg::KIND_DELETE, 1,   32'h0000_0001, 1'b0);
    push_op(pal_pkg::KIND_LOCATE, 0,   32'h0000_0000, 1'b0);
    push_op(pal_pkg::KIND_INSERT, 0,   32'h0000_0001, 1'b0);
    push_op(pal_pkg::KIND_INSERT, 2,   32'h0000_0001, 1'b0);
    push_op(pal_pkg::KIND_INSERT, 1,   32'h8000_0000, 1'b0);
    push_op(pal_pkg::KIND_INSERT, 2,   32'h7FFF_FFFF, 1'b0);
    push_op(pal_pkg::KIND_INSERT, 1,   32'hFFFF_FFFF, 1'b0);
    push_op(pal_pkg::KIND_INSERT, 2,   32'h0000_0000, 1'b0);
    push_op(pal_pkg::KIND_INSERT, 3,   32'h7FFF_FFFF, 1'b0);
    push_op(pal_pkg::KIND_INSERT, 255, 32'h1234_5678, 1'b0);
    push_op(pal_pkg::KIND_LOCATE, 170, 32'h7FFF_FFFF, 1'b0);
    push_op(pal_pkg::KIND_LOCATE, 85,  32'h8000_0000, 1'b0);
    push_op(pal_pkg::KIND_LOCATE, 0,   32'h0000_3039, 1'b0);
    push_op(pal_pkg::KIND_DELETE, 0,   32'h0000_0000, 1'b0);
    push_op(pal_pkg::KIND_DELETE, 6,   32'h0000_0000, 1'b0);
    push_op(pal_pkg::KIND_DELETE, 5,   32'h0000_0000, 1'b0);
    push_op(pal_pkg::KIND_DELETE, 1,   32'h0000_0000, 1'b0);
    push_op(pal_pkg::KIND_DELETE, 2,   32'h0000_0000, 1'b0);
    push_op(pal_pkg::KIND_CLEAR,  255, 32'hFFFF_FFFF, 1'b0);
    push_op(pal_pkg::KIND_CLEAR,  0,   32'h0000_0000, 1'b0);
    push_op(pal_pkg::KIND_LOCATE, 0,   32'hFFFF_FFFF, 1'b0);
    push_op(pal_pkg::KIND_INSERT, 1,   32'h5555_5555, 1'b0);
    push_op(pal_pkg::KIND_INSERT, 2,   32'hAAAA_AAAA, 1'b0);
    push_op(pal_pkg::KIND_DELETE, 1,   32'h0000_0000, 1'b0);
    push_op(pal_pkg::KIND_LOCATE, 0,   32'hAAAA_AAAA, 1'b0);

    // first phase runs the list into the full store and keeps pushing
    gen_phase(PH_GROW, 230);
    n = 230;
    while (n < N_RANDOM) begin
      gen_gaps = $urandom_range(0, 2) != 0;
      r = $urandom_range(40, 150);
      if (r > N_RANDOM - n) r = N_RANDOM - n;
      case ($urandom_range(0, 2))
        0: gen_phase(PH_GROW, r);
        1: gen_phase(PH_SHRINK, r);
        default: gen_phase(PH_MIXED, r);
      endcase
      n += r;
    end
    for (i = op_q.size() - N_TAIL; i < op_q.size(); i++) begin
      op_q[i].gap   = 0;
      op_q[i].drain = 1'b0;
      op_q[i].tail  = 1'b1;
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (op_q.size() != 0 || beats_in != beats_sent || exp_res_q.size() != 0)
      @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    err_cnt += exp_res_q.size();

    $display("run: %0d requests (%0d insert, %0d delete, %0d locate, %0d clear)",
             beats_in, n_kind[pal_pkg::KIND_INSERT], n_kind[pal_pkg::KIND_DELETE],
             n_kind[pal_pkg::KIND_LOCATE], n_kind[pal_pkg::KIND_CLEAR]);
    $display({"run: peak length %0d, %0d full rejects, %0d bad positions, ",
              "%0d hits, %0d mismatches"},
             peak_len, n_full_rej, n_bad, n_hit, err_cnt);
    if (err_cnt == 0) begin
      $display("tb_positional_array_list: clean");
    end else begin
      $display("tb_positional_array_list: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("timeout: %0d of %0d requests sent, %0d results pending",
             beats_sent, beats_sent + op_q.size(), exp_res_q.size());
    $display("tb_positional_array_list: errors");
    $finish;
  end

endmodule

// File: sim.f
sv/pal_pkg.sv
sv/pal_cell.sv
sv/pal_scan.sv
sv/positional_array_list.sv
tb/sv/tb_positional_array_list.sv
